/* rtl/bitmap_id_allocator_unit_macros.svh */
// ----------------------------------------------------------------------------
// bitmap_id_allocator_unit_macros.svh
// Assertion macros used by the allocator checker.
// ----------------------------------------------------------------------------
`ifndef BITMAP_ID_ALLOCATOR_UNIT_MACROS_SVH
`define BITMAP_ID_ALLOCATOR_UNIT_MACROS_SVH

// Same-cycle implication, sampled on clk, quiet during reset
`define BIA_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("bitmap id allocator: same-cycle check failed");

// Next-cycle implication, sampled on clk, quiet during reset
`define BIA_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("bitmap id allocator: next-cycle check failed");

`endif

/* rtl/bia_pkg.sv */
// ----------------------------------------------------------------------------
// bia_pkg
// Shared constants, codes, types and helper functions of the id allocator.
// ----------------------------------------------------------------------------
package bia_pkg;

  // Geometry of the free bitmap: rows of ROW_W bits in one memory
  localparam int ENTRIES = 256;
  localparam int ROW_W   = 16;
  localparam int ROWS    = ENTRIES / ROW_W;
  localparam int ROW_AW  = $clog2(ROWS);
  localparam int BIT_AW  = $clog2(ROW_W);
  localparam int IDX_AW  = ROW_AW + BIT_AW;

  // Field widths
  localparam int OP_W   = 2;
  localparam int PID_W  = 16;
  localparam int STAT_W = 3;
  localparam int CNT_W  = 9;

  // Size after reset, limited to the table depth
  localparam int SIZE_RST_RAW = 256;
  localparam int SIZE_RST     = (SIZE_RST_RAW > ENTRIES) ? ENTRIES : SIZE_RST_RAW;

  // Opcodes
  localparam logic [OP_W-1:0] OP_ACQUIRE = 2'd0;
  localparam logic [OP_W-1:0] OP_FREE    = 2'd1;
  localparam logic [OP_W-1:0] OP_RESET   = 2'd2;

  // Status codes
  localparam logic [STAT_W-1:0] STAT_OK     = 3'd0;
  localparam logic [STAT_W-1:0] STAT_EMPTY  = 3'd1;
  localparam logic [STAT_W-1:0] STAT_FAULT  = 3'd2;
  localparam logic [STAT_W-1:0] STAT_RANGE  = 3'd3;
  localparam logic [STAT_W-1:0] STAT_DOUBLE = 3'd4;
  localparam logic [STAT_W-1:0] STAT_HELD   = 3'd5;

  typedef enum logic {
    FSM_IDLE,
    FSM_EXEC
  } fsm_t;

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [CNT_W-1:0]  granted_id;
    logic [CNT_W-1:0]  free_left;
  } res_t;

  typedef struct packed {
    logic              found;
    logic [BIT_AW-1:0] idx;
  } bit_pick_t;

  typedef struct packed {
    logic              found;
    logic [ROW_AW-1:0] idx;
  } row_pick_t;

  // Lowest set bit of one bitmap row
  function automatic bit_pick_t lowest_bit(input logic [ROW_W-1:0] v);
    bit_pick_t p;
    p = '0;
    for (int b = ROW_W - 1; b >= 0; b--) begin
      if (v[b]) begin
        p.found = 1'b1;
        p.idx   = BIT_AW'(b);
      end
    end
    return p;
  endfunction

  // Lowest row that still holds a free bit
  function automatic row_pick_t lowest_row(input logic [ROWS-1:0] v);
    row_pick_t p;
    p = '0;
    for (int r = ROWS - 1; r >= 0; r--) begin
      if (v[r]) begin
        p.found = 1'b1;
        p.idx   = ROW_AW'(r);
      end
    end
    return p;
  endfunction

  // Contents of a row right after a table reset of the given size
  function automatic logic [ROW_W-1:0] fill_row(input logic [ROW_AW-1:0] row,
                                                input logic [CNT_W-1:0]  size);
    logic [ROW_W-1:0] w;
    logic [IDX_AW:0]  pos;
    w = '0;
    for (int b = 0; b < ROW_W; b++) begin
      pos  = {1'b0, row, BIT_AW'(b)};
      w[b] = (CNT_W'(pos) < size);
    end
    return w;
  endfunction

  // Row summary right after a table reset of the given size
  function automatic logic [ROWS-1:0] fill_summary(input logic [CNT_W-1:0] size);
    logic [ROWS-1:0] s;
    logic [IDX_AW:0] pos;
    s = '0;
    for (int r = 0; r < ROWS; r++) begin
      pos  = {1'b0, ROW_AW'(r), {BIT_AW{1'b0}}};
      s[r] = (CNT_W'(pos) < size);
    end
    return s;
  endfunction

endpackage

/* rtl/bia_if.sv */
// ----------------------------------------------------------------------------
// bia_if
// Valid/ready channels of the id allocator: request, result and config.
// ----------------------------------------------------------------------------
interface bia_in_if;
  import bia_pkg::*;
  logic             valid;
  logic             ready;
  logic [OP_W-1:0]  opcode;
  logic [PID_W-1:0] packet_id;
  logic             recycle_hold;

  modport source (output valid, opcode, packet_id, recycle_hold, input ready);
  modport sink   (input valid, opcode, packet_id, recycle_hold, output ready);
endinterface

interface bia_out_if;
  import bia_pkg::*;
  logic              valid;
  logic              ready;
  logic [STAT_W-1:0] status;
  logic [CNT_W-1:0]  granted_id;
  logic [CNT_W-1:0]  free_left;

  modport source (output valid, status, granted_id, free_left, input ready);
  modport sink   (input valid, status, granted_id, free_left, output ready);
endinterface

interface bia_cfg_if;
  import bia_pkg::*;
  logic             valid;
  logic             ready;
  logic [CNT_W-1:0] data;

  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

/* rtl/bia_ram.sv */
// ----------------------------------------------------------------------------
// bia_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module bia_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Read port, data held until the next read
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

/* rtl/bia_core.sv */
// ----------------------------------------------------------------------------
// bia_core
// Allocator sequencer: picks a bitmap row, reads it, flips one bit and writes
// it back or resets the table, keeping row summary, valid bits, free count.
// ----------------------------------------------------------------------------
module bia_core (
  input  logic                         clk,
  input  logic                         rst_n,
  // request
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [bia_pkg::OP_W-1:0]     in_opcode,
  input  logic [bia_pkg::PID_W-1:0]    in_packet_id,
  input  logic                         in_recycle_hold,
  // config write
  input  logic                         cfg_we,
  input  logic [bia_pkg::CNT_W-1:0]    cfg_data,
  // result slot
  input  logic                         out_free,
  output logic                         done,
  output bia_pkg::res_t                res,
  // bitmap memory
  output logic                         ram_wr_en,
  output logic [bia_pkg::ROW_AW-1:0]   ram_wr_addr,
  output logic [bia_pkg::ROW_W-1:0]    ram_wr_data,
  output logic                         ram_rd_en,
  output logic [bia_pkg::ROW_AW-1:0]   ram_rd_addr,
  input  logic [bia_pkg::ROW_W-1:0]    ram_rd_data
);
  import bia_pkg::*;

  fsm_t               state_r, state_nxt;
  logic [CNT_W-1:0]   table_size_r;
  logic [CNT_W-1:0]   active_r, active_nxt;
  logic [CNT_W-1:0]   total_r, total_nxt;
  logic [ROWS-1:0]    summary_r, summary_nxt;
  logic [ROWS-1:0]    row_valid_r, row_valid_nxt;

  // Latched request
  logic [OP_W-1:0]    op_r;
  logic               hold_r;
  logic               bad_id_r;
  logic               hit_r;
  logic [ROW_AW-1:0]  row_r;
  logic [BIT_AW-1:0]  bit_r;

  logic               in_fire;
  logic               exec_go;
  logic [IDX_AW-1:0]  free_idx;
  row_pick_t          row_pick;
  logic [ROW_W-1:0]   word;
  bit_pick_t          bit_pick;
  logic [CNT_W-1:0]   new_size;

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      FSM_IDLE: if (in_valid) state_nxt = FSM_EXEC;
      FSM_EXEC: if (out_free) state_nxt = FSM_IDLE;
      default:  state_nxt = FSM_IDLE;
    endcase
  end

  // State outputs
  always_comb begin
    in_ready = 1'b0;
    exec_go  = 1'b0;
    unique case (state_r)
      FSM_IDLE: in_ready = 1'b1;
      FSM_EXEC: exec_go  = out_free;
      default:  in_ready = 1'b0;
    endcase
  end

  assign in_fire = in_valid && in_ready;
  assign done    = exec_go;

  // Pick the row to read: lowest row with a free bit, or the row of the id
  assign free_idx    = in_packet_id[IDX_AW-1:0] - IDX_AW'(1);
  assign row_pick    = lowest_row(summary_r);
  assign ram_rd_en   = in_fire;
  assign ram_rd_addr = (in_opcode == OP_FREE) ? free_idx[IDX_AW-1:BIT_AW] : row_pick.idx;

  // Capture the request
  always_ff @(posedge clk) begin
    if (in_fire) begin
      op_r     <= in_opcode;
      hold_r   <= in_recycle_hold;
      bad_id_r <= (in_packet_id == '0) || (in_packet_id > PID_W'(active_r));
      hit_r    <= row_pick.found;
      row_r    <= ram_rd_addr;
      bit_r    <= free_idx[BIT_AW-1:0];
    end
  end

  // Row as it stands: memory data once written, reset pattern before that
  assign word     = row_valid_r[row_r] ? ram_rd_data : fill_row(row_r, active_r);
  assign bit_pick = lowest_bit(word);
  assign new_size = (table_size_r > CNT_W'(ENTRIES)) ? CNT_W'(ENTRIES) : table_size_r;

  // Modify the row and build the result
  always_comb begin
    active_nxt     = active_r;
    total_nxt      = total_r;
    summary_nxt    = summary_r;
    row_valid_nxt  = row_valid_r;
    ram_wr_en      = 1'b0;
    ram_wr_addr    = row_r;
    ram_wr_data    = word;
    res.status     = STAT_OK;
    res.granted_id = '0;
    case (op_r)
      OP_ACQUIRE: begin
        if (total_r == '0) begin
          res.status = STAT_EMPTY;
        end else if (!hit_r || !bit_pick.found) begin
          res.status = STAT_FAULT;
        end else begin
          ram_wr_data                = word;
          ram_wr_data[bit_pick.idx]  = 1'b0;
          ram_wr_en                  = exec_go;
          row_valid_nxt[row_r]       = 1'b1;
          summary_nxt[row_r]         = |ram_wr_data;
          total_nxt                  = total_r - CNT_W'(1);
          res.granted_id             = CNT_W'({row_r, bit_pick.idx}) + CNT_W'(1);
        end
      end
      OP_FREE: begin
        if (bad_id_r) begin
          res.status = STAT_RANGE;
        end else if (hold_r) begin
          res.status = STAT_HELD;
        end else if (word[bit_r]) begin
          res.status = STAT_DOUBLE;
        end else begin
          ram_wr_data          = word;
          ram_wr_data[bit_r]   = 1'b1;
          ram_wr_en            = exec_go;
          row_valid_nxt[row_r] = 1'b1;
          summary_nxt[row_r]   = 1'b1;
          total_nxt            = total_r + CNT_W'(1);
        end
      end
      OP_RESET: begin
        active_nxt    = new_size;
        total_nxt     = new_size;
        summary_nxt   = fill_summary(new_size);
        row_valid_nxt = '0;
      end
      default: begin
        res.status = STAT_FAULT;
      end
    endcase
    res.free_left = total_nxt;
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= FSM_IDLE;
      table_size_r <= CNT_W'(SIZE_RST_RAW);
      active_r     <= CNT_W'(SIZE_RST);
      total_r      <= CNT_W'(SIZE_RST);
      summary_r    <= fill_summary(CNT_W'(SIZE_RST));
      row_valid_r  <= '0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        table_size_r <= cfg_data;
      end
      if (exec_go) begin
        active_r    <= active_nxt;
        total_r     <= total_nxt;
        summary_r   <= summary_nxt;
        row_valid_r <= row_valid_nxt;
      end
    end
  end

endmodule

/* rtl/bitmap_id_allocator_unit.sv */
// ----------------------------------------------------------------------------
// bitmap_id_allocator_unit
// Packet id allocator over a free bitmap held in a row memory.
//
//   channel  dir  payload                               handshake
//   in_chan  in   opcode, packet_id, recycle_hold       valid/ready
//   out_chan out  status, granted_id, free_left         valid/ready
//   cfg_chan in   data (table_size)                     valid/ready, always ready
//
// The bitmap row is read in the accept cycle through the memory's registered
// read port, then modified and written back once the output register is free.
// A new request is taken only once the previous one has reached the output
// register; a stalled result blocks the following request from completing.
// Reset (rst_n low, synchronous) restores a size of 256 with every id free;
// no memory clearing pass is needed, per-row valid bits stand in for it.
// ----------------------------------------------------------------------------
module bitmap_id_allocator_unit (
  input  logic  clk,
  input  logic  rst_n,
  bia_in_if.sink     in_chan,
  bia_out_if.source  out_chan,
  bia_cfg_if.sink    cfg_chan
);
  import bia_pkg::*;

  logic               done;
  res_t               res;
  logic               out_free;
  logic               out_valid_r;
  res_t               out_res_r;
  logic               ram_wr_en;
  logic [ROW_AW-1:0]  ram_wr_addr;
  logic [ROW_W-1:0]   ram_wr_data;
  logic               ram_rd_en;
  logic [ROW_AW-1:0]  ram_rd_addr;
  logic [ROW_W-1:0]   ram_rd_data;

  assign cfg_chan.ready = 1'b1;
  assign out_free       = !out_valid_r || out_chan.ready;

  bia_core u_core (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_chan.valid),
    .in_ready        (in_chan.ready),
    .in_opcode       (in_chan.opcode),
    .in_packet_id    (in_chan.packet_id),
    .in_recycle_hold (in_chan.recycle_hold),
    .cfg_we          (cfg_chan.valid),
    .cfg_data        (cfg_chan.data),
    .out_free        (out_free),
    .done            (done),
    .res             (res),
    .ram_wr_en       (ram_wr_en),
    .ram_wr_addr     (ram_wr_addr),
    .ram_wr_data     (ram_wr_data),
    .ram_rd_en       (ram_rd_en),
    .ram_rd_addr     (ram_rd_addr),
    .ram_rd_data     (ram_rd_data)
  );

  bia_ram #(
    .WIDTH (ROW_W),
    .DEPTH (ROWS)
  ) u_map_ram (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (ram_wr_addr),
    .wr_data (ram_wr_data),
    .rd_en   (ram_rd_en),
    .rd_addr (ram_rd_addr),
    .rd_data (ram_rd_data)
  );

  // Hold the result until the sink takes it
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (done) begin
      out_valid_r <= 1'b1;
    end else if (out_chan.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (done) begin
      out_res_r <= res;
    end
  end

  assign out_chan.valid      = out_valid_r;
  assign out_chan.status     = out_res_r.status;
  assign out_chan.granted_id = out_res_r.granted_id;
  assign out_chan.free_left  = out_res_r.free_left;

endmodule

/* rtl/bia_chk.sv */
// ----------------------------------------------------------------------------
// bia_chk
// Port-level checks of the id allocator, bound to the top level.
// ----------------------------------------------------------------------------
`include "bitmap_id_allocator_unit_macros.svh"

module bia_chk (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_valid,
  input logic                          in_ready,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic [bia_pkg::STAT_W-1:0]    out_status,
  input logic [bia_pkg::CNT_W-1:0]     out_granted_id,
  input logic [bia_pkg::CNT_W-1:0]     out_free_left
);
  import bia_pkg::*;

  // A grant comes only with an ok status
  `BIA_ASSERT_NOW(a_grant_ok, out_valid && (out_granted_id != '0), out_status == STAT_OK)

  // Granted ids stay within the table
  `BIA_ASSERT_NOW(a_grant_in_table, out_valid, out_granted_id <= CNT_W'(ENTRIES))

  // Free counts stay within the table
  `BIA_ASSERT_NOW(a_count_in_table, out_valid, out_free_left <= CNT_W'(ENTRIES))

  // One request at a time: no request is taken right after an accept
  `BIA_ASSERT_NEXT(a_one_at_a_time, in_valid && in_ready, !in_ready)

  // A stalled result stays offered
  `BIA_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid)

endmodule

bind bitmap_id_allocator_unit bia_chk u_chk (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_chan.valid),
  .in_ready       (in_chan.ready),
  .out_valid      (out_chan.valid),
  .out_ready      (out_chan.ready),
  .out_status     (out_chan.status),
  .out_granted_id (out_chan.granted_id),
  .out_free_left  (out_chan.free_left)
);
